>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the look-at view matrix core
// Item formats of the request and response channels, vector types and row codes.
// ----------------------------------------------------------------------------
package lkv_pkg;

   // fraction bits of coordinates (Q16.16) and of unit axis entries (Q1.30)
   localparam int COORD_FRAC_BITS = 16;
   localparam int AXIS_FRAC_BITS  = 30;

   // row codes of the view matrix
   localparam logic [1:0] ROW_U    = 2'd0;
   localparam logic [1:0] ROW_V    = 2'd1;
   localparam logic [1:0] ROW_N    = 2'd2;
   localparam logic [1:0] ROW_LAST = 2'd3;

   // three exact components, index 0 is x
   typedef logic [2:0][63:0] wide_vec_type;
   // three unit axis components in Q1.30, index 0 is x
   typedef logic [2:0][31:0] axis_vec_type;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] up_z;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] col3;
      logic               last_row;
      logic               degenerate;
   } rsp_item_type;

endpackage

>>> rtl/lkv_norm.sv
// ----------------------------------------------------------------------------
// lkv_norm: pipelined vector normalizer
// Scales a three component vector to Q1.30 unit length: magnitude, binary
// scaling search, sum of squares, one square root digit per stage and one
// quotient bit per stage for all three components. Flags the zero vector.
// ----------------------------------------------------------------------------
module lkv_norm #(
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  lkv_pkg::wide_vec_type in_vec,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output lkv_pkg::axis_vec_type out_vec,
   output logic                  out_zero,
   output logic [SIDE_W-1:0]     out_side
);
   import lkv_pkg::*;

   localparam int NRS    = 6;
   localparam int NLS    = 5;
   localparam int NRT    = 32;
   localparam int NDV    = 31;
   localparam int S_MAX  = 1;
   localparam int S_RS0  = S_MAX + 1;
   localparam int S_LS0  = S_RS0 + NRS;
   localparam int S_SQR  = S_LS0 + NLS;
   localparam int S_SUM  = S_SQR + 1;
   localparam int S_RT0  = S_SUM + 1;
   localparam int S_DIV0 = S_RT0 + NRT;
   localparam int S_OUT  = S_DIV0 + NDV + 1;
   localparam int NL     = S_OUT + 1;

   logic              vld_ff  [NL];
   logic [SIDE_W-1:0] side_ff [NL];
   logic [2:0]        sgn_ff  [S_OUT];
   logic              zero_ff [S_MAX:S_OUT];

   wide_vec_type      mag_ff;
   wide_vec_type      shf_ff  [S_MAX:S_SQR-1];
   logic [63:0]       mx_ff   [S_MAX:S_SQR-2];
   logic [63:0]       mx01;
   logic [63:0]       mx_in;

   logic [2:0][61:0]  sq_ff;
   logic [2:0][30:0]  mq_ff   [S_SQR:S_DIV0-1];
   logic [63:0]       sum_ff;
   logic [63:0]       rx_ff   [S_RT0:S_DIV0-1];
   logic [63:0]       rr_ff   [S_RT0:S_DIV0-1];

   logic [31:0]       len_w;
   logic [2:0][61:0]  num_w;
   logic [2:0][61:0]  dn_ff   [S_DIV0:S_OUT-2];
   logic [2:0][31:0]  drem_ff [S_DIV0:S_OUT-2];
   logic [31:0]       dl_ff   [S_DIV0:S_OUT-2];
   logic [2:0][30:0]  dq_ff   [S_DIV0+1:S_OUT-1];
   axis_vec_type      out_ff;

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NL; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < NL; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   // sideband, signs and zero flag travel with the item
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int i = 0; i < 3; i++) sgn_ff[0][i] <= in_vec[i][63];
         for (int s = 1; s < NL; s++) side_ff[s] <= side_ff[s-1];
         for (int s = 1; s < S_OUT; s++) sgn_ff[s] <= sgn_ff[s-1];
         zero_ff[S_MAX] <= (mx_in == 64'd0);
         for (int s = S_MAX + 1; s <= S_OUT; s++) zero_ff[s] <= zero_ff[s-1];
      end
   end

   // magnitudes
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++)
            mag_ff[i] <= in_vec[i][63] ? (64'd0 - in_vec[i]) : in_vec[i];
      end
   end

   assign mx01  = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign mx_in = (mx01 > mag_ff[2]) ? mx01 : mag_ff[2];

   always_ff @(posedge clock) begin
      if (adv) begin
         shf_ff[S_MAX] <= mag_ff;
         mx_ff[S_MAX]  <= mx_in;
      end
   end

   // bring the largest magnitude below 2^31, truncating the others
   for (genvar r = 0; r < NRS; r++) begin : g_rsh
      localparam int K = 32 >> r;
      localparam int S = S_RS0 + r;
      always_ff @(posedge clock) begin
         if (adv) begin
            if ((mx_ff[S-1] >> (30 + K)) != 64'd0) begin
               mx_ff[S] <= mx_ff[S-1] >> K;
               for (int i = 0; i < 3; i++) shf_ff[S][i] <= shf_ff[S-1][i] >> K;
            end else begin
               mx_ff[S]  <= mx_ff[S-1];
               shf_ff[S] <= shf_ff[S-1];
            end
         end
      end
   end

   // bring the largest magnitude up to at least 2^30
   for (genvar l = 0; l < NLS; l++) begin : g_lsh
      localparam int K = 16 >> l;
      localparam int S = S_LS0 + l;
      logic up_w;
      assign up_w = (mx_ff[S-1] < (64'd1 << (31 - K)));
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++)
               shf_ff[S][i] <= up_w ? (shf_ff[S-1][i] << K) : shf_ff[S-1][i];
         end
      end
      if (l < NLS - 1) begin : g_mx
         always_ff @(posedge clock) begin
            if (adv) mx_ff[S] <= up_w ? (mx_ff[S-1] << K) : mx_ff[S-1];
         end
      end
   end

   // squares and their sum
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]        <= shf_ff[S_SQR-1][i][30:0] * shf_ff[S_SQR-1][i][30:0];
            mq_ff[S_SQR][i] <= shf_ff[S_SQR-1][i][30:0];
         end
         for (int s = S_SQR + 1; s < S_DIV0; s++) mq_ff[s] <= mq_ff[s-1];
         sum_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      end
   end

   // square root, one result digit per stage
   for (genvar j = 0; j < NRT; j++) begin : g_rt
      localparam int S = S_RT0 + j;
      localparam logic [63:0] B = 64'd1 << (62 - 2 * j);
      logic [63:0] x_cur;
      logic [63:0] r_cur;
      logic [64:0] t_cur;
      if (j == 0) begin : g_first
         assign x_cur = sum_ff;
         assign r_cur = 64'd0;
      end else begin : g_next
         assign x_cur = rx_ff[S-1];
         assign r_cur = rr_ff[S-1];
      end
      assign t_cur = {1'b0, r_cur} + {1'b0, B};
      always_ff @(posedge clock) begin
         if (adv) begin
            if ({1'b0, x_cur} >= t_cur) begin
               rx_ff[S] <= x_cur - t_cur[63:0];
               rr_ff[S] <= (r_cur >> 1) + B;
            end else begin
               rx_ff[S] <= x_cur;
               rr_ff[S] <= r_cur >> 1;
            end
         end
      end
   end

   // quotient setup: numerator m * 2^30 + len / 2
   assign len_w = rr_ff[S_DIV0-1][31:0];
   always_comb begin
      for (int i = 0; i < 3; i++)
         num_w[i] = {1'b0, mq_ff[S_DIV0-1][i], 30'd0} + {31'd0, len_w[31:1]};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dl_ff[S_DIV0] <= len_w;
         dn_ff[S_DIV0] <= num_w;
         for (int i = 0; i < 3; i++) drem_ff[S_DIV0][i] <= {1'b0, num_w[i][61:31]};
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar t = 0; t < NDV; t++) begin : g_div
      localparam int S = S_DIV0 + 1 + t;
      localparam int J = NDV - 1 - t;
      logic [2:0][32:0] rem2;
      logic [2:0]       qb;
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            rem2[i] = {drem_ff[S-1][i], dn_ff[S-1][i][J]};
            qb[i]   = (rem2[i] >= {1'b0, dl_ff[S-1]});
         end
      end
      if (t == 0) begin : g_q0
         always_ff @(posedge clock) begin
            if (adv) begin
               for (int i = 0; i < 3; i++) dq_ff[S][i] <= {30'd0, qb[i]};
            end
         end
      end else begin : g_qn
         always_ff @(posedge clock) begin
            if (adv) begin
               for (int i = 0; i < 3; i++) dq_ff[S][i] <= {dq_ff[S-1][i][29:0], qb[i]};
            end
         end
      end
      if (t < NDV - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               dn_ff[S] <= dn_ff[S-1];
               dl_ff[S] <= dl_ff[S-1];
               for (int i = 0; i < 3; i++)
                  drem_ff[S][i] <= qb[i] ? 32'(rem2[i] - {1'b0, dl_ff[S-1]}) : rem2[i][31:0];
            end
         end
      end
   end

   // restore signs, force the zero vector
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            if (zero_ff[S_OUT-1])          out_ff[i] <= 32'd0;
            else if (sgn_ff[S_OUT-1][i])   out_ff[i] <= 32'd0 - {1'b0, dq_ff[S_OUT-1][i]};
            else                           out_ff[i] <= {1'b0, dq_ff[S_OUT-1][i]};
         end
      end
   end

   assign out_valid = vld_ff[S_OUT];
   assign out_vec   = out_ff;
   assign out_zero  = zero_ff[S_OUT];
   assign out_side  = side_ff[S_OUT];

endmodule

>>> rtl/look_at_view_matrix_core.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_core: fixed point look-at view matrix
// An item with eye, target and up (signed Q16.16) yields the four rows of the
// view matrix. Rows 0..2 carry axes u, v, n in Q1.30 and -(axis . eye) in
// Q16.16; row 3 is 0, 0, 0, 1.0. A zero-length vector raises degenerate.
//
// Request channel req_valid / req_stall / req_item takes one item per edge
// with req_valid high and req_stall low. Response channel rsp_valid /
// rsp_stall / rsp_item gives four items per request, rows 0 to 3 in order.
// Row 0 enters the output register once the request has passed the input
// register, both normalizers and the cross product stages; rows 1..3 follow.
// The single response port sets sustained throughput; the pipeline takes
// one request per cycle until its last stage holds a request being emitted.
// Each normalizer spends 80 stages: scaling search, 32 square root digit
// stages and 31 quotient bit stages.
// Reset empties the pipeline and the output register. When rsp_stall holds,
// the pipeline freezes once its last stage is occupied and req_stall rises;
// nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lkv_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lkv_pkg::rsp_item_type rsp_item
);
   import lkv_pkg::*;

   localparam int V_TAIL = 8;
   localparam logic [31:0] ONE_COORD = 32'd1 << COORD_FRAC_BITS;

   typedef struct packed {
      axis_vec_type     eye;
      axis_vec_type     up;
   } side1_type;

   typedef struct packed {
      axis_vec_type     eye;
      axis_vec_type     n;
      logic             zero;
   } side2_type;

   typedef struct packed {
      axis_vec_type     u;
      axis_vec_type     v;
      axis_vec_type     n;
      logic [31:0]      tu;
      logic [31:0]      tv;
      logic [31:0]      tn;
      axis_vec_type     eye;
      logic             degen;
   } frame_type;

   function automatic logic [31:0] round_sat(input logic signed [63:0] x, input logic negate);
      logic [63:0] mag;
      logic [33:0] m;
      logic        neg;
      mag = x[63] ? (64'd0 - 64'(x)) : 64'(x);
      m   = 34'((mag + (64'd1 << (AXIS_FRAC_BITS - 1))) >> AXIS_FRAC_BITS);
      neg = x[63] ^ negate;
      if (neg) begin
         if (m >= 34'h0_8000_0000) return 32'h8000_0000;
         return 32'(34'd0 - m);
      end
      if (m >= 34'h0_8000_0000) return 32'h7FFF_FFFF;
      return m[31:0];
   endfunction

   logic               adv;
   logic               load;
   logic               vl_ff [V_TAIL+1];

   side1_type          side1_in;
   side1_type          t0_side_ff;
   wide_vec_type       t0_d_ff;

   logic               n1_valid;
   axis_vec_type       n1_vec;
   logic               n1_zero;
   side1_type          n1_side;

   logic signed [63:0] x1_p_ff [6];
   side2_type          x1_side_ff;
   wide_vec_type       x2_c_ff;
   side2_type          x2_side_ff;

   logic               n2_valid;
   axis_vec_type       n2_vec;
   logic               n2_zero;
   side2_type          n2_side;

   frame_type          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [63:0] v1_p_ff [12];
   logic signed [63:0] v2_s_ff [5];
   logic signed [63:0] v4_p_ff [3];
   logic signed [63:0] v5_s_ff;

   logic [1:0]         row_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff;
   rsp_item_type       rsp_in;

   // the whole pipeline moves unless its last stage still has rows to emit
   assign load      = vl_ff[V_TAIL] && (!rsp_valid_ff || !rsp_stall);
   assign adv       = !vl_ff[V_TAIL] || (load && row_ff == ROW_LAST);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= V_TAIL; s++) vl_ff[s] <= 1'b0;
      end else if (adv) begin
         vl_ff[0] <= req_valid;
         vl_ff[1] <= n1_valid;
         vl_ff[2] <= vl_ff[1];
         vl_ff[3] <= n2_valid;
         for (int s = 4; s <= V_TAIL; s++) vl_ff[s] <= vl_ff[s-1];
      end
   end

   // view direction eye - target, exact
   always_comb begin
      side1_in.eye[0] = req_item.eye_x;
      side1_in.eye[1] = req_item.eye_y;
      side1_in.eye[2] = req_item.eye_z;
      side1_in.up[0]  = req_item.up_x;
      side1_in.up[1]  = req_item.up_y;
      side1_in.up[2]  = req_item.up_z;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_side_ff <= side1_in;
         t0_d_ff[0] <= 64'(req_item.eye_x) - 64'(req_item.target_x);
         t0_d_ff[1] <= 64'(req_item.eye_y) - 64'(req_item.target_y);
         t0_d_ff[2] <= 64'(req_item.eye_z) - 64'(req_item.target_z);
      end
   end

   lkv_norm #(
      .SIDE_W ($bits(side1_type))
   ) u_norm_n (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vl_ff[0]),
      .in_vec    (t0_d_ff),
      .in_side   (t0_side_ff),
      .out_valid (n1_valid),
      .out_vec   (n1_vec),
      .out_zero  (n1_zero),
      .out_side  (n1_side)
   );

   // up x n
   always_ff @(posedge clock) begin
      if (adv) begin
         x1_p_ff[0]      <= $signed(n1_side.up[1]) * $signed(n1_vec[2]);
         x1_p_ff[1]      <= $signed(n1_side.up[2]) * $signed(n1_vec[1]);
         x1_p_ff[2]      <= $signed(n1_side.up[2]) * $signed(n1_vec[0]);
         x1_p_ff[3]      <= $signed(n1_side.up[0]) * $signed(n1_vec[2]);
         x1_p_ff[4]      <= $signed(n1_side.up[0]) * $signed(n1_vec[1]);
         x1_p_ff[5]      <= $signed(n1_side.up[1]) * $signed(n1_vec[0]);
         x1_side_ff.eye  <= n1_side.eye;
         x1_side_ff.n    <= n1_vec;
         x1_side_ff.zero <= n1_zero;
         x2_c_ff[0]      <= x1_p_ff[0] - x1_p_ff[1];
         x2_c_ff[1]      <= x1_p_ff[2] - x1_p_ff[3];
         x2_c_ff[2]      <= x1_p_ff[4] - x1_p_ff[5];
         x2_side_ff      <= x1_side_ff;
      end
   end

   lkv_norm #(
      .SIDE_W ($bits(side2_type))
   ) u_norm_u (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vl_ff[2]),
      .in_vec    (x2_c_ff),
      .in_side   (x2_side_ff),
      .out_valid (n2_valid),
      .out_vec   (n2_vec),
      .out_zero  (n2_zero),
      .out_side  (n2_side)
   );

   // n x u and the translation dot products
   always_ff @(posedge clock) begin
      if (adv) begin
         v1_ff.u     <= n2_vec;
         v1_ff.v     <= n2_vec;
         v1_ff.n     <= n2_side.n;
         v1_ff.tu    <= 32'd0;
         v1_ff.tv    <= 32'd0;
         v1_ff.tn    <= 32'd0;
         v1_ff.eye   <= n2_side.eye;
         v1_ff.degen <= n2_side.zero | n2_zero;
         v1_p_ff[0]  <= $signed(n2_side.n[1]) * $signed(n2_vec[2]);
         v1_p_ff[1]  <= $signed(n2_side.n[2]) * $signed(n2_vec[1]);
         v1_p_ff[2]  <= $signed(n2_side.n[2]) * $signed(n2_vec[0]);
         v1_p_ff[3]  <= $signed(n2_side.n[0]) * $signed(n2_vec[2]);
         v1_p_ff[4]  <= $signed(n2_side.n[0]) * $signed(n2_vec[1]);
         v1_p_ff[5]  <= $signed(n2_side.n[1]) * $signed(n2_vec[0]);
         for (int i = 0; i < 3; i++) begin
            v1_p_ff[6+i] <= $signed(n2_vec[i]) * $signed(n2_side.eye[i]);
            v1_p_ff[9+i] <= $signed(n2_side.n[i]) * $signed(n2_side.eye[i]);
         end

         v2_ff      <= v1_ff;
         v2_s_ff[0] <= v1_p_ff[0] - v1_p_ff[1];
         v2_s_ff[1] <= v1_p_ff[2] - v1_p_ff[3];
         v2_s_ff[2] <= v1_p_ff[4] - v1_p_ff[5];
         v2_s_ff[3] <= v1_p_ff[6] + v1_p_ff[7] + v1_p_ff[8];
         v2_s_ff[4] <= v1_p_ff[9] + v1_p_ff[10] + v1_p_ff[11];

         v3_ff.u     <= v2_ff.u;
         v3_ff.n     <= v2_ff.n;
         v3_ff.tv    <= v2_ff.tv;
         v3_ff.eye   <= v2_ff.eye;
         v3_ff.degen <= v2_ff.degen;
         for (int i = 0; i < 3; i++) v3_ff.v[i] <= round_sat(v2_s_ff[i], 1'b0);
         v3_ff.tu <= round_sat(v2_s_ff[3], 1'b1);
         v3_ff.tn <= round_sat(v2_s_ff[4], 1'b1);

         v4_ff <= v3_ff;
         for (int i = 0; i < 3; i++)
            v4_p_ff[i] <= $signed(v3_ff.v[i]) * $signed(v3_ff.eye[i]);

         v5_ff   <= v4_ff;
         v5_s_ff <= v4_p_ff[0] + v4_p_ff[1] + v4_p_ff[2];

         v6_ff.u     <= v5_ff.u;
         v6_ff.v     <= v5_ff.v;
         v6_ff.n     <= v5_ff.n;
         v6_ff.tu    <= v5_ff.tu;
         v6_ff.tn    <= v5_ff.tn;
         v6_ff.eye   <= v5_ff.eye;
         v6_ff.degen <= v5_ff.degen;
         v6_ff.tv    <= round_sat(v5_s_ff, 1'b1);
      end
   end

   // row select for the output register
   always_comb begin
      rsp_in            = rsp_ff;
      rsp_in.row_index  = row_ff;
      rsp_in.last_row   = (row_ff == ROW_LAST);
      rsp_in.degenerate = v6_ff.degen;
      case (row_ff)
         ROW_U: begin
            rsp_in.col0 = v6_ff.u[0];
            rsp_in.col1 = v6_ff.u[1];
            rsp_in.col2 = v6_ff.u[2];
            rsp_in.col3 = v6_ff.tu;
         end
         ROW_V: begin
            rsp_in.col0 = v6_ff.v[0];
            rsp_in.col1 = v6_ff.v[1];
            rsp_in.col2 = v6_ff.v[2];
            rsp_in.col3 = v6_ff.tv;
         end
         ROW_N: begin
            rsp_in.col0 = v6_ff.n[0];
            rsp_in.col1 = v6_ff.n[1];
            rsp_in.col2 = v6_ff.n[2];
            rsp_in.col3 = v6_ff.tn;
         end
         default: begin
            rsp_in.col0 = 32'd0;
            rsp_in.col1 = 32'd0;
            rsp_in.col2 = 32'd0;
            rsp_in.col3 = ONE_COORD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         row_ff       <= ROW_U;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            row_ff       <= row_ff + 2'd1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> rtl/lkv_chk.sv
// ----------------------------------------------------------------------------
// lkv_chk: port checker for the look-at view matrix core
// Watches the response channel for reset behavior, hold under stall and the
// order and shape of the four rows of each matrix.
// ----------------------------------------------------------------------------
module lkv_chk (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input lkv_pkg::rsp_item_type rsp_item
);
   import lkv_pkg::*;

   // reset empties the output
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled response item changed");

   // last row flag matches the row number
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.last_row == (rsp_item.row_index == ROW_LAST))
      else $error("last_row does not match row_index");

   // row 3 has a zero rotation part
   a_row3: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.row_index == ROW_LAST |->
         rsp_item.col0 == 32'sd0 && rsp_item.col1 == 32'sd0 && rsp_item.col2 == 32'sd0)
      else $error("row 3 rotation part not zero");

   // rows of one matrix follow in order with one degenerate flag
   a_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_item.last_row) ##1 rsp_valid |->
         rsp_item.row_index == $past(rsp_item.row_index) + 2'd1 &&
         rsp_item.degenerate == $past(rsp_item.degenerate))
      else $error("response rows out of order");

endmodule

bind look_at_view_matrix_core lkv_chk u_lkv_chk (.*);

>>> tb/sv/tb_look_at_view_matrix_core.sv
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix_core: self-checking bench of the look-at view matrix
// Builds each of the four expected matrix rows from eye, target and up with an
// exact integer predictor. Sends directed corner items and then random items,
// with random idle gaps on the request side and random stalls on the response
// side. Compares every response item field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix_core;
   import lkv_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   rsp_item_type expected_rows[$];
   int           error_count;
   int           rows_checked;
   int           items_sent;
   int           degenerate_seen;

   look_at_view_matrix_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic longint sat_word(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // divide by 2^k, rounding half away from zero
   function automatic longint round_away(longint x, int k);
      longint unsigned m;
      m = x < 0 ? -x : x;
      m = (m + (64'd1 << (k - 1))) >> k;
      return x < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // scale to unit length in Q1.30; return 1 on a zero vector
   function automatic bit unit_axis(input longint c[3], output longint a[3]);
      longint unsigned m[3], mx, sum, len, q;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = c[i] < 0 ? -c[i] : c[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) a[i] = 0;
         return 1'b1;
      end
      while (mx < (64'd1 << 30)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      while (mx >= (64'd1 << 31)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 30) + (len >> 1)) / len;
         a[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b0;
   endfunction

   function automatic logic [31:0] eye_offset(input longint a[3], input longint e[3]);
      longint dot;
      dot = a[0] * e[0] + a[1] * e[1] + a[2] * e[2];
      return 32'(sat_word(round_away(-dot, AXIS_FRAC_BITS)));
   endfunction

   task automatic predict_view_rows(input req_item_type it);
      longint eye[3], tgt[3], up[3], dir[3], side_raw[3], n[3], u[3], v[3];
      bit degen;
      rsp_item_type r;
      eye = '{longint'(it.eye_x), longint'(it.eye_y), longint'(it.eye_z)};
      tgt = '{longint'(it.target_x), longint'(it.target_y), longint'(it.target_z)};
      up  = '{longint'(it.up_x), longint'(it.up_y), longint'(it.up_z)};
      for (int i = 0; i < 3; i++) dir[i] = eye[i] - tgt[i];
      degen = unit_axis(dir, n);
      side_raw[0] = up[1] * n[2] - up[2] * n[1];
      side_raw[1] = up[2] * n[0] - up[0] * n[2];
      side_raw[2] = up[0] * n[1] - up[1] * n[0];
      if (unit_axis(side_raw, u)) degen = 1'b1;
      v[0] = sat_word(round_away(n[1] * u[2] - n[2] * u[1], AXIS_FRAC_BITS));
      v[1] = sat_word(round_away(n[2] * u[0] - n[0] * u[2], AXIS_FRAC_BITS));
      v[2] = sat_word(round_away(n[0] * u[1] - n[1] * u[0], AXIS_FRAC_BITS));
      if (degen) degenerate_seen++;
      r.last_row = 1'b0;
      r.degenerate = degen;
      r.row_index = ROW_U;
      r.col0 = 32'(u[0]); r.col1 = 32'(u[1]); r.col2 = 32'(u[2]);
      r.col3 = eye_offset(u, eye);
      expected_rows.push_back(r);
      r.row_index = ROW_V;
      r.col0 = 32'(v[0]); r.col1 = 32'(v[1]); r.col2 = 32'(v[2]);
      r.col3 = eye_offset(v, eye);
      expected_rows.push_back(r);
      r.row_index = ROW_N;
      r.col0 = 32'(n[0]); r.col1 = 32'(n[1]); r.col2 = 32'(n[2]);
      r.col3 = eye_offset(n, eye);
      expected_rows.push_back(r);
      r.row_index = ROW_LAST;
      r.col0 = 0; r.col1 = 0; r.col2 = 0; r.col3 = 32'sd1 <<< COORD_FRAC_BITS;
      r.last_row = 1'b1;
      expected_rows.push_back(r);
   endtask

   // response stall: redraw a hold length after each accepted item
   initial begin
      int hold;
      rsp_stall = 1'b0;
      hold = 0;
      @(posedge clock);
      forever begin
         if (rsp_valid && !rsp_stall) hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         else if (hold > 0) hold--;
         rsp_stall <= (hold > 0);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rows.size() == 0) begin
            $error("response item with nothing expected: row %0d", rsp_item.row_index);
            error_count++;
         end else begin
            e = expected_rows.pop_front();
            rows_checked++;
            if (rsp_item.row_index !== e.row_index) begin
               $error("row_index: expected %0d, got %0d", e.row_index, rsp_item.row_index);
               error_count++;
            end
            if (rsp_item.col0 !== e.col0) begin
               $error("col0: expected %0d, got %0d", e.col0, rsp_item.col0);
               error_count++;
            end
            if (rsp_item.col1 !== e.col1) begin
               $error("col1: expected %0d, got %0d", e.col1, rsp_item.col1);
               error_count++;
            end
            if (rsp_item.col2 !== e.col2) begin
               $error("col2: expected %0d, got %0d", e.col2, rsp_item.col2);
               error_count++;
            end
            if (rsp_item.col3 !== e.col3) begin
               $error("col3: expected %0d, got %0d", e.col3, rsp_item.col3);
               error_count++;
            end
            if (rsp_item.last_row !== e.last_row) begin
               $error("last_row: expected %0b, got %0b", e.last_row, rsp_item.last_row);
               error_count++;
            end
            if (rsp_item.degenerate !== e.degenerate) begin
               $error("degenerate: expected %0b, got %0b", e.degenerate,
                      rsp_item.degenerate);
               error_count++;
            end
         end
      end
   end

   // send one item after a random gap; valid stays up across back-to-back items
   task automatic send_view(input req_item_type it);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_view_rows(it);
      items_sent++;
   endtask

   function automatic req_item_type make_view(longint ex, longint ey, longint ez,
                                              longint tx, longint ty, longint tz,
                                              longint ux, longint uy, longint uz);
      req_item_type it;
      it.eye_x = 32'(ex); it.eye_y = 32'(ey); it.eye_z = 32'(ez);
      it.target_x = 32'(tx); it.target_y = 32'(ty); it.target_z = 32'(tz);
      it.up_x = 32'(ux); it.up_y = 32'(uy); it.up_z = 32'(uz);
      return it;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return $signed($urandom_range(0, 20) - 10) <<< 16;
         3: return $signed($urandom_range(0, 8) - 4);
         default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   task automatic test_directed_views();
      localparam longint ONE = 64'sd1 <<< COORD_FRAC_BITS;
      localparam longint MAXC = 64'sd2147483647;
      localparam longint MINC = -64'sd2147483648;
      send_view(make_view(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
      send_view(make_view(3 * ONE, 2 * ONE, ONE, 0, ONE, 0, 0, ONE, 0));
      // eye on target
      send_view(make_view(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0));
      send_view(make_view(0, 0, 0, 0, 0, 0, 0, 0, 0));
      // up along view direction, and zero up
      send_view(make_view(0, 5 * ONE, 0, 0, 0, 0, 0, ONE, 0));
      send_view(make_view(0, 0, ONE, 0, 0, 0, 0, 0, 0));
      // extremes: widest difference and saturated translation
      send_view(make_view(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC, MINC));
      send_view(make_view(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MAXC));
      send_view(make_view(MAXC, MINC, MAXC, MAXC, MINC, MAXC - 1, MAXC, MAXC, MINC));
      send_view(make_view(MINC, MAXC, MINC, 0, 0, 0, 1, -1, 1));
      send_view(make_view(MAXC, MAXC, MAXC, MAXC - 1, MAXC, MAXC, 0, MINC, 0));
      send_view(make_view(1, 0, 0, 0, 0, 0, 0, 1, 0));
      send_view(make_view(-1, -1, -1, 0, 0, 0, -1, 0, 1));
      send_view(make_view(-32'sh5555_5555, 32'sh2AAA_AAAA, -7, 9, -32'sh1234_5678,
                          32'sh7654_3210, -ONE, ONE, -ONE));
   endtask

   task automatic test_random_views();
      req_item_type it;
      for (int k = 0; k < 190; k++) begin
         it = make_view(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord());
         case ($urandom_range(0, 19))
            0: it.target_x = it.eye_x;
            1: {it.target_x, it.target_y, it.target_z} = {it.eye_x, it.eye_y, it.eye_z};
            2: {it.up_x, it.up_y, it.up_z} = {it.eye_x - it.target_x,
                   it.eye_y - it.target_y, it.eye_z - it.target_z};
            default: ;
         endcase
         send_view(it);
      end
      // drop valid after the last item
      req_valid <= 1'b0;
   endtask

   initial begin
      int wait_cycles;
      error_count = 0;
      rows_checked = 0;
      items_sent = 0;
      degenerate_seen = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_views();
      test_random_views();
      wait_cycles = 0;
      while (expected_rows.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);
      if (expected_rows.size() != 0) begin
         $error("%0d expected rows never arrived", expected_rows.size());
         error_count++;
      end
      $display("Sent %0d views (%0d degenerate), checked %0d matrix rows.",
               items_sent, degenerate_seen, rows_checked);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

>>> look_at_view_matrix_core.f
rtl/lkv_pkg.sv
rtl/lkv_norm.sv
rtl/look_at_view_matrix_core.sv
rtl/lkv_chk.sv
tb/sv/tb_look_at_view_matrix_core.sv
